### design/kpef_pkg.sv
// ----------------------------------------------------------------------------
// kpef_pkg
// shared widths, defaults, action codes and queue control word
// ----------------------------------------------------------------------------
`default_nettype none

package kpef_pkg;

   localparam int MASK_W          = 5;
   localparam int CODE_W          = 3;
   localparam int COUNT_W         = 5;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int KEY_COUNT_DEF   = 5;

   typedef enum logic [1:0] {
      ACT_SCAN  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_INIT  = 2'd3
   } action_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              flush;
      logic [CODE_W-1:0] code;
   } queue_ctl_type;

endpackage

`default_nettype wire

### design/kpef_ram.sv
// ----------------------------------------------------------------------------
// kpef_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module kpef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/kpef_queue.sv
// ----------------------------------------------------------------------------
// kpef_queue
// key fifo: ring pointers, fill count, head prefetch with write bypass
// ----------------------------------------------------------------------------
`default_nettype none

module kpef_queue
   import kpef_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire queue_ctl_type                    ctl,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0] fill,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0] fill_next,
   output logic      [CODE_W-1:0]                head_code
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              byp_ff, byp_in;
   logic [CODE_W-1:0] byp_data_ff;
   logic [CODE_W-1:0] ram_rd_data;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.flush) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (ctl.push) begin
         tail_in = ptr_inc(tail_ff);
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         head_in = ptr_inc(head_ff);
         fill_in = fill_ff - 1'b1;
      end
   end

   // head entry written in the same cycle it is fetched
   assign byp_in = ctl.push && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         byp_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         byp_ff  <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= ctl.code;
   end

   kpef_ram #(
      .WIDTH (CODE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (ctl.code),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   assign fill      = fill_ff;
   assign fill_next = fill_in;
   assign head_code = byp_ff ? byp_data_ff : ram_rd_data;

endmodule

`default_nettype wire

### design/key_press_edge_fifo.sv
// ----------------------------------------------------------------------------
// key_press_edge_fifo
// key press edge detector feeding a key fifo
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    req_action, req_pressed_mask
//   rsp      out        rsp_valid/ready    rsp_key_code, rsp_queued_count,
//                                          rsp_queue_nonempty
//
// one word per cycle while rsp is not stalled; rsp valid follows the accepting req edge
// through the input register, then the result register
// the head of the fifo ram is prefetched each cycle, so a pop needs no wait
// a stalled rsp holds the result register and the input register fills;
// req_ready drops only when both are occupied
// synchronous reset clears control, previous mask and fifo pointers
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_edge_fifo
   import kpef_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [MASK_W-1:0]  req_pressed_mask,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [CODE_W-1:0]  rsp_key_code,
   output logic      [COUNT_W-1:0] rsp_queued_count,
   output logic                    rsp_queue_nonempty
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic              s1_valid_ff, s1_valid_in;
   action_type        s1_action_ff;
   logic [MASK_W-1:0] s1_mask_ff;
   logic [MASK_W-1:0] prev_mask_ff, prev_mask_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_key_code_ff, rsp_key_code_in;
   logic [COUNT_W-1:0] rsp_queued_count_ff;
   logic               rsp_queue_nonempty_ff;

   logic              advance;
   logic              req_take;
   logic [MASK_W-1:0] rising;
   logic [CODE_W-1:0] hit;
   logic              full;
   queue_ctl_type     ctl;
   logic [FILL_W-1:0] fill, fill_next;
   logic [CODE_W-1:0] head_code;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // lowest newly pressed key
   assign rising = s1_mask_ff & ~prev_mask_ff;

   always_comb begin
      hit = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if ((i < KEY_COUNT) && rising[i]) begin
            hit = CODE_W'(i + 1);
         end
      end
   end

   assign full = (fill == FILL_W'(QUEUE_DEPTH));

   always_comb begin
      ctl             = '0;
      ctl.code        = hit;
      prev_mask_in    = prev_mask_ff;
      rsp_key_code_in = '0;
      if (advance) begin
         unique case (s1_action_ff)
            ACT_SCAN: begin
               if (!full) begin
                  prev_mask_in = s1_mask_ff;
                  ctl.push     = (hit != '0);
               end
            end
            ACT_POP: begin
               if (fill != '0) begin
                  ctl.pop         = 1'b1;
                  rsp_key_code_in = head_code;
               end
            end
            ACT_CLEAR: begin
               ctl.flush = 1'b1;
            end
            ACT_INIT: begin
               ctl.flush    = 1'b1;
               prev_mask_in = s1_mask_ff;
            end
            default: begin
               ctl.flush = 1'b0;
            end
         endcase
      end
   end

   kpef_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .fill      (fill),
      .fill_next (fill_next),
      .head_code (head_code)
   );

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_mask_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_mask_ff <= prev_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= action_type'(req_action);
         s1_mask_ff   <= req_pressed_mask;
      end
      if (advance) begin
         rsp_key_code_ff       <= rsp_key_code_in;
         rsp_queued_count_ff   <= COUNT_W'(fill_next);
         rsp_queue_nonempty_ff <= (fill_next != '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_code       = rsp_key_code_ff;
   assign rsp_queued_count   = rsp_queued_count_ff;
   assign rsp_queue_nonempty = rsp_queue_nonempty_ff;

endmodule

`default_nettype wire

### verif/key_press_edge_fifo_tb.sv
// ----------------------------------------------------------------------------
// key_press_edge_fifo_tb
// self-checking bench for the key press edge detector and its key fifo
//
// words go in through req and come back through rsp. Each accepted word runs
// through a local predictor that keeps its own last mask and key backlog.
// Every rsp word is checked field by field against the oldest prediction.
// Directed cases cover the edge rules and a full queue. Random traffic then
// runs in phases with sender gaps and receiver stalls, and one long rsp
// hold-off fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_press_edge_fifo_tb;
   import kpef_pkg::*;

   localparam int HOLD_CYCLES = 120;

   typedef struct {
      action_type         act;
      logic [CODE_W-1:0]  code;
      logic [COUNT_W-1:0] count;
      logic               nonempty;
   } key_result_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [1:0]        req_action       = ACT_SCAN;
   logic [MASK_W-1:0] req_pressed_mask = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [CODE_W-1:0]  rsp_key_code;
   logic [COUNT_W-1:0] rsp_queued_count;
   logic               rsp_queue_nonempty;

   logic [MASK_W-1:0]  last_mask = '0;
   logic [CODE_W-1:0]  key_backlog[$];
   key_result_type     expected_results[$];
   int                 mismatch_count = 0;
   int                 send_idle_pct  = 0;
   int                 rsp_stall_pct  = 0;
   logic               rsp_hold       = 1'b0;
   event               hold_go;

   key_press_edge_fifo dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_pressed_mask   (req_pressed_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_code       (rsp_key_code),
      .rsp_queued_count   (rsp_queued_count),
      .rsp_queue_nonempty (rsp_queue_nonempty)
   );

   always #5 clock = ~clock;

   function automatic key_result_type predict_key_result(input action_type act,
                                                          input logic [MASK_W-1:0] mask);
      key_result_type    res;
      logic [MASK_W-1:0] rising;
      int                hit;
      res.act  = act;
      res.code = '0;
      hit      = 0;
      case (act)
         ACT_SCAN: begin
            if (key_backlog.size() < QUEUE_DEPTH_DEF) begin
               rising    = mask & ~last_mask;
               last_mask = mask;
               for (int i = 0; i < KEY_COUNT_DEF && i < MASK_W; i++)
                  if (hit == 0 && rising[i]) hit = i + 1;
               if (hit != 0) key_backlog.push_back(CODE_W'(hit));
            end
         end
         ACT_POP: begin
            if (key_backlog.size() > 0) res.code = key_backlog.pop_front();
         end
         ACT_CLEAR: begin
            key_backlog.delete();
         end
         default: begin
            last_mask = mask;
            key_backlog.delete();
         end
      endcase
      res.count    = COUNT_W'(key_backlog.size());
      res.nonempty = key_backlog.size() != 0;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_word(input action_type act, input logic [MASK_W-1:0] mask);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_pressed_mask <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_key_result(act, mask));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // checks each rsp word, then decides ready for the next edge
   always @(posedge clock) begin : rsp_side
      key_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("rsp word with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (rsp_key_code !== want.code)
               report_mismatch($sformatf("%s key_code %0d, want %0d",
                               want.act.name(), rsp_key_code, want.code));
            if (rsp_queued_count !== want.count)
               report_mismatch($sformatf("%s queued_count %0d, want %0d",
                               want.act.name(), rsp_queued_count, want.count));
            if (rsp_queue_nonempty !== want.nonempty)
               report_mismatch($sformatf("%s queue_nonempty %0b, want %0b",
                               want.act.name(), rsp_queue_nonempty, want.nonempty));
         end
      end
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long rsp hold-off, counted here
   initial forever begin
      @(hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic test_directed_cases();
      send_word(ACT_POP,   5'b00000);
      send_word(ACT_SCAN,  5'b00000);
      send_word(ACT_SCAN,  5'b00001);
      send_word(ACT_SCAN,  5'b00011);
      send_word(ACT_SCAN,  5'b11111);
      send_word(ACT_SCAN,  5'b11111);
      send_word(ACT_SCAN,  5'b00000);
      send_word(ACT_SCAN,  5'b10000);
      repeat (4) send_word(ACT_POP, 5'b11111);
      send_word(ACT_POP,   5'b10101);
      send_word(ACT_SCAN,  5'b01000);
      send_word(ACT_CLEAR, 5'b00000);
      send_word(ACT_SCAN,  5'b01000);
      send_word(ACT_INIT,  5'b11111);
      send_word(ACT_SCAN,  5'b11111);
      send_word(ACT_SCAN,  5'b01111);
      send_word(ACT_SCAN,  5'b11111);
      send_word(ACT_POP,   5'b00000);
      send_word(ACT_INIT,  5'b00000);
   endtask

   task automatic test_full_queue();
      send_word(ACT_INIT, 5'b00000);
      for (int n = 0; n < QUEUE_DEPTH_DEF; n++)
         send_word(ACT_SCAN, n[0] ? 5'b00010 : 5'b00001);
      send_word(ACT_SCAN,  5'b00100);
      send_word(ACT_POP,   5'b00000);
      send_word(ACT_SCAN,  5'b00110);
      send_word(ACT_SCAN,  5'b00000);
      send_word(ACT_CLEAR, 5'b11111);
      send_word(ACT_POP,   5'b00000);
   endtask

   task automatic test_random_traffic(input int words, input int idle_pct, input int stall_pct);
      logic [MASK_W-1:0] held;
      action_type        act;
      int                fill_bias;
      int                pick;
      int                bit_sel;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      held          = '0;
      fill_bias     = 50;
      for (int n = 0; n < words; n++) begin
         if (n % 40 == 0) fill_bias = $urandom_range(20, 90);
         if ($urandom_range(99) < 15) begin
            held = MASK_W'($urandom);
         end else begin
            bit_sel       = $urandom_range(MASK_W - 1);
            held[bit_sel] = ~held[bit_sel];
         end
         pick = $urandom_range(99);
         if (pick < fill_bias) act = ACT_SCAN;
         else if (pick < 98)   act = ACT_POP;
         else if (pick < 99)   act = ACT_CLEAR;
         else                  act = ACT_INIT;
         send_word(act, held);
      end
      wait_drain();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_go;
      for (int n = 0; n < 30; n++)
         send_word($urandom_range(3) == 0 ? ACT_POP : ACT_SCAN, MASK_W'($urandom));
      wait_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_queue();
      wait_drain();
      test_random_traffic(170, 0, 0);
      test_random_traffic(170, 63, 0);
      test_output_backpressure();
      test_random_traffic(170, 0, 63);
      test_random_traffic(170, 25, 25);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[key_press_edge_fifo] OK");
      end else begin
         $display("[key_press_edge_fifo] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[key_press_edge_fifo] ERROR");
      $finish;
   end

endmodule
